FILE: hw/rtl/cls_pkg.sv
// ---------------------------------------------------------------------------
// cls_pkg
// Shared types and codes of the Cholesky solver controller and datapath.
// ---------------------------------------------------------------------------
package cls_pkg;

	localparam int DATA_W = 32;

	localparam logic [1:0] MD_FACT = 2'd0;
	localparam logic [1:0] MD_FWD  = 2'd1;
	localparam logic [1:0] MD_BACK = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] i;
		logic [2:0] j;
		logic [2:0] k;
		logic       ld;
		logic       clr_acc;
		logic       rd_dot;
		logic       mul;
		logic       acc;
		logic       rd_base;
		logic       diff;
		logic       sqrt_go;
		logic       div_go;
		logic       wr_res;
		logic       out_ld;
		logic       out_err;
		logic       out_last;
	} cls_cmd_t;

	typedef struct packed {
		logic d_nonpos;
		logic den_nonpos;
		logic unit_done;
	} cls_sts_t;

endpackage

FILE: hw/rtl/cls_iter.sv
// ---------------------------------------------------------------------------
// cls_iter
// Shared bit-serial unit: fixed-point square root and saturating divide.
// ---------------------------------------------------------------------------
module cls_iter #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sqrt_go,
	input  logic               div_go,
	input  logic signed [31:0] d,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] result
);

	localparam int SQ_W  = 2 * ((32 + FRAC_BITS) / 2);
	localparam int RT_W  = SQ_W / 2;
	localparam int DV_W  = 32 + FRAC_BITS;
	localparam int CNT_W = $clog2(DV_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             is_sqrt_q;
	logic             neg_q;
	logic [SQ_W-1:0]  rad_q;
	logic [RT_W:0]    srem_q;
	logic [RT_W-1:0]  root_q;
	logic [DV_W-1:0]  dvd_q;
	logic [31:0]      drem_q;
	logic [31:0]      den_q;

	logic [RT_W+2:0]  sr_t;
	logic [RT_W+2:0]  s_trial;
	logic             s_ge;
	logic [32:0]      dr_t;
	logic             d_ge;
	logic [31:0]      mag;
	logic             q_big;
	logic [31:0]      sat_w;

	assign sr_t    = {srem_q, rad_q[SQ_W-1 -: 2]};
	assign s_trial = {1'b0, root_q, 2'b01};
	assign s_ge    = sr_t >= s_trial;
	assign dr_t    = {drem_q, dvd_q[DV_W-1]};
	assign d_ge    = dr_t >= {1'b0, den_q};
	assign mag     = d[31] ? (~d + 32'd1) : d;
	assign q_big   = |dvd_q[DV_W-1:31];

	always_comb begin
		if (!neg_q) begin
			sat_w = q_big ? 32'h7FFF_FFFF : dvd_q[31:0];
		end else begin
			sat_w = q_big ? 32'h8000_0000 : (~dvd_q[31:0] + 32'd1);
		end
	end

	assign result = is_sqrt_q ? $signed(32'(root_q)) : $signed(sat_w);
	assign done   = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (sqrt_go) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RT_W);
			end else if (div_go) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sqrt_go) begin
			is_sqrt_q <= 1'b1;
			rad_q     <= SQ_W'({d, {FRAC_BITS{1'b0}}});
			srem_q    <= '0;
			root_q    <= '0;
		end else if (div_go) begin
			is_sqrt_q <= 1'b0;
			neg_q     <= d[31];
			dvd_q     <= {mag, {FRAC_BITS{1'b0}}};
			drem_q    <= '0;
			den_q     <= den;
		end else if (busy_q) begin
			if (is_sqrt_q) begin
				rad_q <= rad_q << 2;
				if (s_ge) begin
					srem_q <= (RT_W+1)'(sr_t - s_trial);
					root_q <= {root_q[RT_W-2:0], 1'b1};
				end else begin
					srem_q <= (RT_W+1)'(sr_t);
					root_q <= {root_q[RT_W-2:0], 1'b0};
				end
			end else begin
				if (d_ge) begin
					drem_q <= 32'(dr_t - {1'b0, den_q});
					dvd_q  <= {dvd_q[DV_W-2:0], 1'b1};
				end else begin
					drem_q <= dr_t[31:0];
					dvd_q  <= {dvd_q[DV_W-2:0], 1'b0};
				end
			end
		end
	end

endmodule

FILE: hw/rtl/cls_dpath.sv
// ---------------------------------------------------------------------------
// cls_dpath
// Solver datapath: factor memory, vector stores, multiply-accumulate,
// difference and saturation, shared root/divide unit, result register.
// ---------------------------------------------------------------------------
module cls_dpath import cls_pkg::*; #(
	parameter int MAX_DIM   = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cls_cmd_t                 cmd,
	output cls_sts_t                 sts,
	input  logic                     opcode,
	input  logic [2:0]               row,
	input  logic [2:0]               col,
	input  logic signed [DATA_W-1:0] value,
	output logic [2:0]               index,
	output logic signed [DATA_W-1:0] solution,
	output logic                     pivot_error,
	output logic                     last_res
);

	localparam int FD = MAX_DIM * MAX_DIM;
	localparam int AW = $clog2(FD);
	localparam int IW = $clog2(MAX_DIM);
	localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

	function automatic logic [AW-1:0] faddr(input logic [2:0] r, input logic [2:0] c);
		faddr = AW'(16'(r) * 16'(MAX_DIM) + 16'(c));
	endfunction

	logic signed [DATA_W-1:0] fmem [FD];
	logic signed [DATA_W-1:0] rhs_q [MAX_DIM];
	logic signed [DATA_W-1:0] fwdv_q [MAX_DIM];
	logic signed [DATA_W-1:0] solv_q [MAX_DIM];

	logic signed [DATA_W-1:0] fa_q;
	logic signed [DATA_W-1:0] fb_q;
	logic signed [DATA_W-1:0] vb_q;
	logic signed [63:0]       prod_q;
	logic signed [63:0]       acc_q;
	logic signed [DATA_W-1:0] d_q;

	logic [2:0]               index_q;
	logic signed [DATA_W-1:0] solution_q;
	logic                     pivot_error_q;
	logic                     last_res_q;

	logic                     ld_fac;
	logic                     ld_rhs;
	logic                     fwe;
	logic [AW-1:0]            fwa;
	logic signed [DATA_W-1:0] fwdat;
	logic [AW-1:0]            aa;
	logic [AW-1:0]            ab;
	logic [IW-1:0]            vi;
	logic [IW-1:0]            ii;
	logic signed [DATA_W-1:0] opb;
	logic signed [DATA_W-1:0] base_w;
	logic signed [63:0]       diff_w;
	logic signed [DATA_W-1:0] iter_res;
	logic                     iter_done;
	logic                     is_fact;

	assign is_fact = cmd.mode == MD_FACT;
	assign ld_fac  = cmd.ld & ~opcode & (col <= row) & (int'(row) < MAX_DIM);
	assign ld_rhs  = cmd.ld & opcode & (int'(row) < MAX_DIM);
	assign fwe     = ld_fac | (cmd.wr_res & is_fact);
	assign fwa     = cmd.ld ? faddr(row, col) : faddr(cmd.i, cmd.j);
	assign fwdat   = cmd.ld ? value : iter_res;

	always_comb begin
		if (cmd.rd_dot) begin
			aa = (cmd.mode == MD_BACK) ? faddr(cmd.k, cmd.i) : faddr(cmd.i, cmd.k);
			ab = faddr(cmd.j, cmd.k);
		end else begin
			aa = is_fact ? faddr(cmd.i, cmd.j) : faddr(cmd.i, cmd.i);
			ab = is_fact ? faddr(cmd.j, cmd.j) : faddr(cmd.i, cmd.i);
		end
	end

	assign vi = cmd.rd_dot ? IW'(cmd.k) : IW'(cmd.i);
	assign ii = IW'(cmd.i);

	always_ff @(posedge clk) begin
		if (fwe) begin
			fmem[fwa] <= fwdat;
		end
		if (cmd.rd_dot | cmd.rd_base) begin
			fa_q <= fmem[aa];
			fb_q <= fmem[ab];
		end
	end

	always_ff @(posedge clk) begin
		if (ld_rhs) begin
			rhs_q[IW'(row)] <= value;
		end
		if (cmd.wr_res && cmd.mode == MD_FWD) begin
			fwdv_q[ii] <= iter_res;
		end
		if (cmd.wr_res && cmd.mode == MD_BACK) begin
			solv_q[ii] <= iter_res;
		end
		if (cmd.rd_dot) begin
			vb_q <= (cmd.mode == MD_BACK) ? solv_q[vi] : fwdv_q[vi];
		end else if (cmd.rd_base) begin
			vb_q <= (cmd.mode == MD_BACK) ? fwdv_q[vi] : rhs_q[vi];
		end
	end

	assign opb    = is_fact ? fb_q : vb_q;
	assign base_w = is_fact ? fa_q : vb_q;
	assign diff_w = 64'(base_w) - acc_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= 64'(fa_q) * 64'(opb);
		end
		if (cmd.clr_acc) begin
			acc_q <= '0;
		end else if (cmd.acc) begin
			acc_q <= acc_q + ((prod_q + HALF) >>> FRAC_BITS);
		end
		if (cmd.diff) begin
			if (diff_w > 64'sd2147483647) begin
				d_q <= 32'sh7FFF_FFFF;
			end else if (diff_w < -64'sd2147483648) begin
				d_q <= 32'sh8000_0000;
			end else begin
				d_q <= diff_w[31:0];
			end
		end
	end

	cls_iter #(
		.FRAC_BITS(FRAC_BITS)
	) u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.sqrt_go(cmd.sqrt_go),
		.div_go (cmd.div_go),
		.d      (d_q),
		.den    (fb_q),
		.done   (iter_done),
		.result (iter_res)
	);

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			index_q       <= cmd.i;
			solution_q    <= cmd.out_err ? '0 : solv_q[vi];
			pivot_error_q <= cmd.out_err;
			last_res_q    <= cmd.out_last;
		end
	end

	assign sts.d_nonpos   = d_q <= 0;
	assign sts.den_nonpos = fb_q <= 0;
	assign sts.unit_done  = iter_done;

	assign index       = index_q;
	assign solution    = solution_q;
	assign pivot_error = pivot_error_q;
	assign last_res    = last_res_q;

endmodule

FILE: hw/rtl/cls_ctrl.sv
// ---------------------------------------------------------------------------
// cls_ctrl
// Solver sequencer: loads, factorization, diagonal check, forward and back
// substitution, result emission.
// ---------------------------------------------------------------------------
module cls_ctrl import cls_pkg::*; #(
	parameter int MAX_DIM = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       opcode,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	output cls_cmd_t   cmd,
	input  cls_sts_t   sts
);

	localparam int NLIM = (MAX_DIM < 8) ? MAX_DIM : 8;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ELEM = 4'd1;
	localparam logic [3:0] S_DRD  = 4'd2;
	localparam logic [3:0] S_DMUL = 4'd3;
	localparam logic [3:0] S_DACC = 4'd4;
	localparam logic [3:0] S_BRD  = 4'd5;
	localparam logic [3:0] S_DIFF = 4'd6;
	localparam logic [3:0] S_EVAL = 4'd7;
	localparam logic [3:0] S_UNIT = 4'd8;
	localparam logic [3:0] S_WR   = 4'd9;
	localparam logic [3:0] S_CRD  = 4'd10;
	localparam logic [3:0] S_CCHK = 4'd11;
	localparam logic [3:0] S_EMIT = 4'd12;

	logic [3:0] state_q;
	logic [1:0] mode_q;
	logic [2:0] i_q;
	logic [2:0] j_q;
	logic [3:0] k_q;
	logic [3:0] dim_q;
	logic       pbad_q;
	logic       err_q;
	logic       ovld_q;

	logic [3:0] n;
	logic [2:0] nm1;
	logic       acc_in;
	logic       out_free;
	logic [3:0] lim;
	logic [3:0] k0;
	logic [3:0] k_nx;
	logic       diag;

	always_comb begin
		if (dim_q == 4'd0) begin
			n = 4'd1;
		end else if (dim_q > 4'(NLIM)) begin
			n = 4'(NLIM);
		end else begin
			n = dim_q;
		end
	end

	assign nm1      = 3'(n - 4'd1);
	assign in_stall = state_q != S_IDLE;
	assign acc_in   = in_valid & ~in_stall;
	assign out_free = ~ovld_q | ~out_stall;
	assign out_valid = ovld_q;
	assign diag     = i_q == j_q;
	assign k_nx     = k_q + 4'd1;

	always_comb begin
		case (mode_q)
			MD_FACT: begin
				lim = {1'b0, j_q};
				k0  = 4'd0;
			end
			MD_BACK: begin
				lim = n;
				k0  = {1'b0, i_q} + 4'd1;
			end
			default: begin
				lim = {1'b0, i_q};
				k0  = 4'd0;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.mode = mode_q;
		cmd.i    = i_q;
		cmd.j    = j_q;
		cmd.k    = k_q[2:0];
		case (state_q)
			S_IDLE: cmd.ld = acc_in;
			S_ELEM: cmd.clr_acc = 1'b1;
			S_DRD:  cmd.rd_dot = 1'b1;
			S_DMUL: cmd.mul = 1'b1;
			S_DACC: cmd.acc = 1'b1;
			S_BRD:  cmd.rd_base = 1'b1;
			S_CRD:  cmd.rd_base = 1'b1;
			S_DIFF: cmd.diff = 1'b1;
			S_EVAL: begin
				cmd.sqrt_go = (mode_q == MD_FACT) & diag & ~sts.d_nonpos;
				cmd.div_go  = ~((mode_q == MD_FACT) & diag);
			end
			S_WR:   cmd.wr_res = 1'b1;
			S_EMIT: begin
				cmd.out_ld   = out_free;
				cmd.out_err  = err_q;
				cmd.out_last = i_q == nm1;
			end
			default: cmd.ld = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= MD_FACT;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			dim_q   <= 4'd8;
			pbad_q  <= 1'b0;
			err_q   <= 1'b0;
			ovld_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				dim_q <= cfg_wdata;
			end
			ovld_q <= cmd.out_ld | (ovld_q & out_stall);
			case (state_q)
				S_IDLE: begin
					if (acc_in && last) begin
						i_q <= '0;
						j_q <= '0;
						if (!opcode) begin
							pbad_q  <= 1'b0;
							mode_q  <= MD_FACT;
							state_q <= S_ELEM;
						end else begin
							err_q   <= pbad_q;
							mode_q  <= MD_FWD;
							state_q <= S_CRD;
						end
					end
				end
				S_ELEM: begin
					k_q     <= k0;
					state_q <= (k0 < lim) ? S_DRD : S_BRD;
				end
				S_DRD:  state_q <= S_DMUL;
				S_DMUL: state_q <= S_DACC;
				S_DACC: begin
					k_q     <= k_nx;
					state_q <= (k_nx < lim) ? S_DRD : S_BRD;
				end
				S_BRD:  state_q <= S_DIFF;
				S_DIFF: state_q <= S_EVAL;
				S_EVAL: begin
					if (mode_q == MD_FACT && diag && sts.d_nonpos) begin
						pbad_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_UNIT;
					end
				end
				S_UNIT: begin
					if (sts.unit_done) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					case (mode_q)
						MD_FACT: begin
							if (diag) begin
								if (i_q == nm1) begin
									state_q <= S_IDLE;
								end else begin
									i_q     <= i_q + 3'd1;
									j_q     <= '0;
									state_q <= S_ELEM;
								end
							end else begin
								j_q     <= j_q + 3'd1;
								state_q <= S_ELEM;
							end
						end
						MD_FWD: begin
							if (i_q == nm1) begin
								mode_q <= MD_BACK;
							end else begin
								i_q <= i_q + 3'd1;
							end
							state_q <= S_ELEM;
						end
						MD_BACK: begin
							if (i_q == 3'd0) begin
								state_q <= S_EMIT;
							end else begin
								i_q     <= i_q - 3'd1;
								state_q <= S_ELEM;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_CRD: state_q <= S_CCHK;
				S_CCHK: begin
					if (sts.den_nonpos) begin
						err_q <= 1'b1;
					end
					if (i_q == nm1) begin
						i_q <= '0;
						if (err_q || sts.den_nonpos) begin
							state_q <= S_EMIT;
						end else begin
							mode_q  <= MD_FWD;
							state_q <= S_ELEM;
						end
					end else begin
						i_q     <= i_q + 3'd1;
						state_q <= S_CRD;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						if (i_q == nm1) begin
							state_q <= S_IDLE;
						end else begin
							i_q <= i_q + 3'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/cholesky_linear_solver.sv
// ---------------------------------------------------------------------------
// cholesky_linear_solver
// Fixed-point Cholesky factorization and triangular solve of A x = b.
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+-----
//   in      | in_valid in_stall opcode row col value last | in
//   out     | out_valid out_stall index solution          | out
//           | pivot_error last_res                      |
//   cfg     | cfg_we cfg_wdata (dimension)              | in
//
// Each factor or solve element runs a read, multiply and accumulate step per
// multiply-accumulate term, then a base read, a difference and the shared
// bit-serial unit: a root for a factor diagonal, else a divide. The solve
// adds a diagonal check of each row and emits one result per row. in_stall
// is high from a trigger item until the factorization ends or the last result
// is loaded. Reset clears control state only; stores hold garbage.
// ---------------------------------------------------------------------------
module cholesky_linear_solver import cls_pkg::*; #(
	parameter int MAX_DIM   = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic [2:0]               row,
	input  logic [2:0]               col,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     last,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [2:0]               index,
	output logic signed [DATA_W-1:0] solution,
	output logic                     pivot_error,
	output logic                     last_res,
	input  logic                     cfg_we,
	input  logic [3:0]               cfg_wdata
);

	cls_cmd_t cmd;
	cls_sts_t sts;

	cls_ctrl #(
		.MAX_DIM(MAX_DIM)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.last     (last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.sts      (sts)
	);

	cls_dpath #(
		.MAX_DIM  (MAX_DIM),
		.FRAC_BITS(FRAC_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.opcode     (opcode),
		.row        (row),
		.col        (col),
		.value      (value),
		.index      (index),
		.solution   (solution),
		.pivot_error(pivot_error),
		.last_res   (last_res)
	);

endmodule

FILE: hw/rtl/cls_chk.sv
// ---------------------------------------------------------------------------
// cls_chk
// Port-level checks for the Cholesky solver, bound to the top level.
// ---------------------------------------------------------------------------
module cls_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] solution,
	input logic        pivot_error
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(solution))
		else $error("stalled result changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pivot_error |-> solution == 32'd0)
		else $error("error result with nonzero solution");

	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !last |=> !in_stall)
		else $error("plain load item stalled the input");

endmodule

bind cholesky_linear_solver cls_chk u_cls_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.last       (last),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.solution   (solution),
	.pivot_error(pivot_error)
);
